[sv/cma_pkg.sv]
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the constant modulus equalizer.
// ----------------------------------------------------------------------------
package cma_pkg;

    typedef struct packed {
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
    } t_out;

    // Datapath commands from the controller.
    typedef struct packed {
        logic win_load;
        logic win_rot;
        logic acc_clr;
        logic mac_en;
        logic y_en;
        logic mag_en;
        logic prod_en;
        logic err_en;
        logic coef_en;
        logic tap_en;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic y_load;
    } t_stat;

    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_STEP_GAIN = 2'd1;
    localparam logic [1:0] REG_DECIM     = 2'd2;

    localparam logic [16:0] MODULUS_RST   = 17'd32768;
    localparam logic [15:0] STEP_GAIN_RST = 16'd66;
    localparam logic [4:0]  DECIM_RST     = 5'd2;

    localparam logic signed [23:0] TAP_ONE = 24'sd1048576;

endpackage

[sv/cma_ctrl.sv]
// ----------------------------------------------------------------------------
// cma_ctrl
// Handshake, decimation phase and sequencing of the equalizer passes.
// ----------------------------------------------------------------------------
module cma_ctrl import cma_pkg::*; #(
    parameter int NTAPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [4:0] i_decim,
    output t_cmd       o_cmd,
    output t_stat      o_stat
);

    localparam int CW = $clog2(NTAPS + 2);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MAC  = 7'b0000010,
        ST_SAT  = 7'b0000100,
        ST_MAG  = 7'b0001000,
        ST_PROD = 7'b0010000,
        ST_CLIP = 7'b0100000,
        ST_UPD  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_phase, n_phase;
    logic          r_ov, n_ov;
    logic [4:0]    period;
    logic [3:0]    phase_now;
    logic [4:0]    phase_inc;
    logic          fire;
    logic          in_acc;

    always_comb begin
        if (i_decim == 5'd0) begin
            period = 5'd1;
        end else if (i_decim > 5'd16) begin
            period = 5'd16;
        end else begin
            period = i_decim;
        end
        phase_now = ({1'b0, r_phase} >= period) ? 4'd0 : r_phase;
        phase_inc = {1'b0, phase_now} + 5'd1;
        fire      = (phase_now == 4'd0);
    end

    // A sample that fires cannot be taken while the last result still waits.
    assign o_in_stall = !((r_state == ST_IDLE) && (!r_ov || !fire));
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_ov    = r_ov;
        o_cmd   = '0;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.win_load = 1'b1;
                    n_phase = (phase_inc >= period) ? 4'd0 : phase_inc[3:0];
                    if (fire) begin
                        o_cmd.acc_clr = 1'b1;
                        n_cnt   = '0;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.win_rot = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NTAPS - 1)) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.y_en = 1'b1;
                n_ov    = 1'b1;
                n_state = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag_en = 1'b1;
                n_state = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state = ST_CLIP;
            end
            ST_CLIP: begin
                o_cmd.err_en = 1'b1;
                n_cnt   = '0;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                // Coefficient stage runs one tap ahead of the tap write stage.
                if (r_cnt < CW'(NTAPS)) begin
                    o_cmd.coef_en = 1'b1;
                    o_cmd.win_rot = 1'b1;
                end
                if (r_cnt != '0) begin
                    o_cmd.tap_en = 1'b1;
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NTAPS)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_phase <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_stat.busy   = (r_state != ST_IDLE);
    assign o_stat.y_load = (r_state == ST_SAT);

endmodule

[sv/cma_dp.sv]
// ----------------------------------------------------------------------------
// cma_dp
// Sample window, taps, filter accumulator, error term and tap update.
// ----------------------------------------------------------------------------
module cma_dp import cma_pkg::*; #(
    parameter int NTAPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in         i_in_data,
    input  logic [16:0] i_modulus,
    input  logic [15:0] i_step_gain,
    output t_out        o_out_data
);

    localparam int ACC_W = 42 + $clog2(NTAPS);
    localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(524288);
    localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN  = ACC_W'(-32768);
    localparam logic signed [49:0] E_HALF = 50'sd536870912;
    localparam logic signed [49:0] E_MAX  = 50'sd32768;
    localparam logic signed [49:0] E_MIN  = -50'sd32768;
    localparam logic signed [50:0] D_HALF = 51'sd33554432;
    localparam logic signed [50:0] T_MAX  = 51'sd8388607;
    localparam logic signed [50:0] T_MIN  = -51'sd8388608;

    logic signed [15:0] r_xi [NTAPS];
    logic signed [15:0] r_xq [NTAPS];
    logic signed [23:0] r_wi [NTAPS];
    logic signed [23:0] r_wq [NTAPS];

    logic signed [ACC_W-1:0] r_acc_i, r_acc_q;
    logic signed [15:0]      r_yi, r_yq;
    logic [31:0]             r_mag;
    logic signed [49:0]      r_pe_i, r_pe_q;
    logic signed [16:0]      r_ei, r_eq;
    logic signed [33:0]      r_cr, r_ci;

    logic signed [40:0]      m_i, m_q;
    logic signed [ACC_W-1:0] t_yi, t_yq;
    logic signed [31:0]      sq_i, sq_q;
    logic signed [33:0]      d;
    logic signed [49:0]      t_ei, t_eq;
    logic signed [33:0]      c_r, c_i;
    logic signed [50:0]      dr, di, nw_i, nw_q;
    logic signed [50:0]      mu;

    assign m_i = 41'(r_xi[0]) * 41'(r_wi[0]) - 41'(r_xq[0]) * 41'(r_wq[0]);
    assign m_q = 41'(r_xi[0]) * 41'(r_wq[0]) + 41'(r_xq[0]) * 41'(r_wi[0]);

    assign t_yi = (r_acc_i + Y_HALF) >>> 20;
    assign t_yq = (r_acc_q + Y_HALF) >>> 20;

    assign sq_i = r_yi * r_yi;
    assign sq_q = r_yq * r_yq;

    assign d = $signed({2'b00, r_mag}) - $signed({2'b00, i_modulus, 15'b0});

    assign t_ei = (r_pe_i + E_HALF) >>> 30;
    assign t_eq = (r_pe_q + E_HALF) >>> 30;

    assign c_r = 34'(r_xi[0]) * 34'(r_ei) + 34'(r_xq[0]) * 34'(r_eq);
    assign c_i = 34'(r_xi[0]) * 34'(r_eq) - 34'(r_xq[0]) * 34'(r_ei);

    assign mu   = $signed({35'b0, i_step_gain});
    assign dr   = (51'(r_cr) * mu + D_HALF) >>> 26;
    assign di   = (51'(r_ci) * mu + D_HALF) >>> 26;
    assign nw_i = 51'(r_wi[0]) - dr;
    assign nw_q = 51'(r_wq[0]) - di;

    // Window: shift in on a new sample, rotate so that entry 0 walks the taps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NTAPS; k++) begin
                r_xi[k] <= '0;
                r_xq[k] <= '0;
            end
        end else if (i_cmd.win_load) begin
            r_xi[0] <= i_in_data.in_i;
            r_xq[0] <= i_in_data.in_q;
            for (int k = 1; k < NTAPS; k++) begin
                r_xi[k] <= r_xi[k-1];
                r_xq[k] <= r_xq[k-1];
            end
        end else if (i_cmd.win_rot) begin
            for (int k = 0; k < NTAPS - 1; k++) begin
                r_xi[k] <= r_xi[k+1];
                r_xq[k] <= r_xq[k+1];
            end
            r_xi[NTAPS-1] <= r_xi[0];
            r_xq[NTAPS-1] <= r_xq[0];
        end
    end

    // Taps rotate during the MAC pass and take their update at the tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NTAPS; k++) begin
                r_wi[k] <= (k == 0) ? TAP_ONE : 24'sd0;
                r_wq[k] <= '0;
            end
        end else if (i_cmd.mac_en || i_cmd.tap_en) begin
            for (int k = 0; k < NTAPS - 1; k++) begin
                r_wi[k] <= r_wi[k+1];
                r_wq[k] <= r_wq[k+1];
            end
            if (i_cmd.tap_en) begin
                r_wi[NTAPS-1] <= (nw_i > T_MAX) ? 24'(T_MAX) :
                                 (nw_i < T_MIN) ? 24'(T_MIN) : 24'(nw_i);
                r_wq[NTAPS-1] <= (nw_q > T_MAX) ? 24'(T_MAX) :
                                 (nw_q < T_MIN) ? 24'(T_MIN) : 24'(nw_q);
            end else begin
                r_wi[NTAPS-1] <= r_wi[0];
                r_wq[NTAPS-1] <= r_wq[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (i_cmd.mac_en) begin
            r_acc_i <= r_acc_i + ACC_W'(m_i);
            r_acc_q <= r_acc_q + ACC_W'(m_q);
        end
        if (i_cmd.y_en) begin
            r_yi <= (t_yi > Y_MAX) ? 16'sh7fff : (t_yi < Y_MIN) ? 16'sh8000 : 16'(t_yi);
            r_yq <= (t_yq > Y_MAX) ? 16'sh7fff : (t_yq < Y_MIN) ? 16'sh8000 : 16'(t_yq);
        end
        if (i_cmd.mag_en) begin
            r_mag <= $unsigned(sq_i) + $unsigned(sq_q);
        end
        if (i_cmd.prod_en) begin
            r_pe_i <= 50'(r_yi) * 50'(d);
            r_pe_q <= 50'(r_yq) * 50'(d);
        end
        if (i_cmd.err_en) begin
            r_ei <= (t_ei > E_MAX) ? 17'(E_MAX) : (t_ei < E_MIN) ? 17'(E_MIN) : 17'(t_ei);
            r_eq <= (t_eq > E_MAX) ? 17'(E_MAX) : (t_eq < E_MIN) ? 17'(E_MIN) : 17'(t_eq);
        end
        if (i_cmd.coef_en) begin
            r_cr <= c_r;
            r_ci <= c_i;
        end
    end

    assign o_out_data.out_i = r_yi;
    assign o_out_data.out_q = r_yq;

endmodule

[sv/cma_adaptive_equalizer.sv]
// ----------------------------------------------------------------------------
// cma_adaptive_equalizer
// Constant modulus blind equalizer with decimated output and APB registers.
// ----------------------------------------------------------------------------
// A sample that produces no output only shifts the window and advances the decimation
// phase. A sample that produces an output occupies the block for a whole pass: complex
// multiply-accumulate over the NTAPS taps through one shared MAC unit, steps that
// saturate y, form the magnitude, the product and the clipped error, and a tap update
// through a two-stage coefficient pipeline. A firing sample is held off while
// the previous result is still waiting to be taken.
module cma_adaptive_equalizer import cma_pkg::*; #(
    parameter int NTAPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [16:0] r_modulus;
    logic [15:0] r_step_gain;
    logic [4:0]  r_decim;
    logic        wr;
    t_cmd        cmd;
    t_stat       stat;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RST;
            r_step_gain <= STEP_GAIN_RST;
            r_decim     <= DECIM_RST;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_MODULUS:   r_modulus   <= pwdata[16:0];
                REG_STEP_GAIN: r_step_gain <= pwdata[15:0];
                REG_DECIM:     r_decim     <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODULUS:   prdata = {15'b0, r_modulus};
            REG_STEP_GAIN: prdata = {16'b0, r_step_gain};
            REG_DECIM:     prdata = {27'b0, r_decim};
            default:       prdata = '0;
        endcase
    end

    cma_ctrl #(.NTAPS(NTAPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_decim     (r_decim),
        .o_cmd       (cmd),
        .o_stat      (stat)
    );

    cma_dp #(.NTAPS(NTAPS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_modulus   (r_modulus),
        .i_step_gain (r_step_gain),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> o_in_stall)
        else $error("input taken while a filter pass is running");
    a_result_from_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stat.y_load))
        else $error("result raised outside the saturation step");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.y_load |-> $past(!o_out_valid || !i_out_stall))
        else $error("pending result overwritten");
`endif

endmodule

[bench/cma_adaptive_equalizer_test.sv]
// ----------------------------------------------------------------------------
// cma_adaptive_equalizer_test
// Self-checking bench for the constant modulus equalizer: an in-bench model
// of the window, taps and decimation predicts every output sample, while
// register settings and idle and stall patterns change from phase to phase.
// ----------------------------------------------------------------------------
module cma_adaptive_equalizer_test;
    import cma_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS = 16;
    localparam int DRAIN_CYCLES = 2 * NTAPS + 20;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cma_adaptive_equalizer #(.NTAPS(NTAPS)) i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Model state.
    longint win_i [NTAPS];
    longint win_q [NTAPS];
    longint tap_i [NTAPS];
    longint tap_q [NTAPS];
    int unsigned phase_pos;
    longint      modulus_r;
    longint      gain_r;
    int unsigned decim_r;

    t_in  sample_queue[$];
    t_out equalized_queue[$];
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   errors = 0;
    int   quiet_cycles = 0;
    logic in_took = 1'b0;

    function automatic longint round_down(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic equalize_sample(input t_in s);
        int unsigned period;
        bit          fire;
        longint      acc_i, acc_q, yi, yq, d, ei, eq, cr, ci;
        t_out        r;
        period = decim_r == 0 ? 1 : (decim_r > 16 ? 16 : decim_r);
        for (int k = NTAPS - 1; k > 0; k--) begin
            win_i[k] = win_i[k - 1];
            win_q[k] = win_q[k - 1];
        end
        win_i[0] = longint'(s.in_i);
        win_q[0] = longint'(s.in_q);
        if (phase_pos >= period) phase_pos = 0;
        fire = (phase_pos == 0);
        phase_pos = (phase_pos + 1 >= period) ? 0 : phase_pos + 1;
        if (fire) begin
            acc_i = 0;
            acc_q = 0;
            for (int k = 0; k < NTAPS; k++) begin
                acc_i += win_i[k] * tap_i[k] - win_q[k] * tap_q[k];
                acc_q += win_i[k] * tap_q[k] + win_q[k] * tap_i[k];
            end
            yi = clip(round_down(acc_i, 20), -32768, 32767);
            yq = clip(round_down(acc_q, 20), -32768, 32767);
            d = yi * yi + yq * yq - (modulus_r <<< 15);
            ei = clip(round_down(yi * d, 30), -32768, 32768);
            eq = clip(round_down(yq * d, 30), -32768, 32768);
            for (int k = 0; k < NTAPS; k++) begin
                cr = win_i[k] * ei + win_q[k] * eq;
                ci = win_i[k] * eq - win_q[k] * ei;
                tap_i[k] = clip(tap_i[k] - round_down(cr * gain_r, 26), -8388608, 8388607);
                tap_q[k] = clip(tap_q[k] - round_down(ci * gain_r, 26), -8388608, 8388607);
            end
            r.out_i = yi[15:0];
            r.out_q = yq[15:0];
            equalized_queue.push_back(r);
        end
    endtask

    // Monitor: register writes, accepted samples and accepted outputs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NTAPS; k++) begin
                win_i[k] = 0;
                win_q[k] = 0;
                tap_i[k] = 0;
                tap_q[k] = 0;
            end
            tap_i[0] = longint'(TAP_ONE);
            phase_pos = 0;
            modulus_r = MODULUS_RST;
            gain_r = STEP_GAIN_RST;
            decim_r = DECIM_RST;
            in_took <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MODULUS:   modulus_r = pwdata[16:0];
                    REG_STEP_GAIN: gain_r = pwdata[15:0];
                    REG_DECIM:     decim_r = pwdata[4:0];
                    default: ;
                endcase
            end
            in_took <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) equalize_sample(i_in_data);
            if (o_out_valid && !i_out_stall) begin
                if (equalized_queue.size() == 0) begin
                    $error("unexpected output transaction %h", o_out_data);
                    errors++;
                end else begin
                    t_out e;
                    e = equalized_queue.pop_front();
                    if (o_out_data.out_i !== e.out_i) begin
                        $error("out_i expected %0d actual %0d", e.out_i, o_out_data.out_i);
                        errors++;
                    end
                    if (o_out_data.out_q !== e.out_q) begin
                        $error("out_q expected %0d actual %0d", e.out_q, o_out_data.out_q);
                        errors++;
                    end
                end
            end
        end
    end

    // Driver for samples and output stall.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (!i_in_valid || in_took) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        wait (sample_queue.size() == 0 && !i_in_valid && equalized_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_random(input int n);
        t_in s;
        for (int j = 0; j < n; j++) begin
            s = $urandom;
            // Some low-level samples keep the loop near its operating point.
            if ($urandom_range(2) == 0) begin
                s.in_i = $signed(s.in_i) >>> 3;
                s.in_q = $signed(s.in_q) >>> 3;
            end
            sample_queue.push_back(s);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples, among them the field extremes, with the reset settings.
        sample_queue.push_back('{16'sh7fff, 16'sh7fff});
        sample_queue.push_back('{-16'sh8000, -16'sh8000});
        sample_queue.push_back('{16'sh7fff, -16'sh8000});
        sample_queue.push_back('{-16'sh8000, 16'sh7fff});
        sample_queue.push_back('{16'sh0000, 16'sh0000});
        sample_queue.push_back('{-16'sh0001, -16'sh0001});
        sample_queue.push_back('{16'sh0001, 16'sh0000});
        sample_queue.push_back('{16'sh4000, 16'sh0000});
        sample_queue.push_back('{16'sh0000, 16'sh4000});
        sample_queue.push_back('{16'sh5555, -16'sh5556});
        sample_queue.push_back('{-16'sh5556, 16'sh5555});
        sample_queue.push_back('{16'sh7fff, 16'sh0000});
        sample_queue.push_back('{16'sh7fff, 16'sh7fff});
        sample_queue.push_back('{16'sh7fff, 16'sh7fff});
        sample_queue.push_back('{-16'sh8000, 16'sh0000});
        sample_queue.push_back('{16'sh2d41, 16'sh2d41});
        drain();

        // Decimation by one with the largest step and modulus.
        reg_write(REG_DECIM, 32'd1);
        reg_write(REG_STEP_GAIN, 32'hffff_ffff);
        reg_write(REG_MODULUS, 32'hffff_ffff);
        add_random(40);
        drain();

        // Zero modulus, zero step and decimation by sixteen; a write to the unused index is ignored.
        send_idle_pct = 66;
        reg_write(REG_MODULUS, 32'd0);
        reg_write(REG_STEP_GAIN, 32'd0);
        reg_write(2'd3, 32'h0000_0003);
        reg_write(REG_DECIM, 32'd16);
        add_random(90);
        drain();

        // A decimation of zero acts as one.
        send_idle_pct = 0;
        stall_pct = 66;
        reg_write(REG_MODULUS, 32'd32768);
        reg_write(REG_STEP_GAIN, 32'd300);
        reg_write(REG_DECIM, 32'd0);
        add_random(70);
        drain();

        // Decimation above sixteen acts as sixteen.
        send_idle_pct = 33;
        stall_pct = 33;
        reg_write(REG_DECIM, 32'd31);
        add_random(80);
        drain();
        reg_write(REG_DECIM, 32'd17);
        add_random(40);
        drain();

        // Shorter period while mid-period, then random settings.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p % 2) ? 66 : 0;
            stall_pct = (p > 1) ? 66 : 0;
            reg_write(REG_DECIM, $urandom_range(1, 5));
            reg_write(REG_MODULUS, $urandom_range(131071));
            reg_write(REG_STEP_GAIN, $urandom_range(2000));
            add_random(55);
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
